[sv/filled_circle_row_masks_macros.svh]
// ----------------------------------------------------------------------------
// Filled circle row masks: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_ROW_MASKS_MACROS_SVH
`define FILLED_CIRCLE_ROW_MASKS_MACROS_SVH

// Same-cycle implication.
`define FCRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FCRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fcrm_pkg.sv]
// ----------------------------------------------------------------------------
// fcrm_pkg
// Constants, micro-op codes, control word type and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrm_pkg;

  localparam int FCRM_MAX_RADIUS = 32;
  localparam int FCRM_ROWS       = 64;
  localparam int FCRM_PC_W       = 5;

  // micro-op codes
  localparam logic [2:0] OP_RD   = 3'd0;  // read the span's row
  localparam logic [2:0] OP_WR   = 3'd1;  // OR the span into the row read before
  localparam logic [2:0] OP_TEST = 3'd2;  // jump to target unless x < y
  localparam logic [2:0] OP_STEP = 3'd3;  // one midpoint step
  localparam logic [2:0] OP_JMP  = 3'd4;  // unconditional jump
  localparam logic [2:0] OP_ERD  = 3'd5;  // read row k for emission
  localparam logic [2:0] OP_EOUT = 3'd6;  // emit row k, loop to target

  // span selects: row, first column, end column
  localparam logic [2:0] SP_MID = 3'd0;  // r,   0,   2r
  localparam logic [2:0] SP_TOP = 3'd1;  // 0,   r,   r+1
  localparam logic [2:0] SP_BOT = 3'd2;  // 2r-1, r,  r+1
  localparam logic [2:0] SP_PY  = 3'd3;  // r+y, r-x, r+x
  localparam logic [2:0] SP_NY  = 3'd4;  // r-y, r-x, r+x
  localparam logic [2:0] SP_PX  = 3'd5;  // r+x, r-y, r+y
  localparam logic [2:0] SP_NX  = 3'd6;  // r-x, r-y, r+y

  localparam logic [FCRM_PC_W-1:0] L_START = 5'd0;
  localparam logic [FCRM_PC_W-1:0] L_LOOP  = 5'd6;
  localparam logic [FCRM_PC_W-1:0] L_EMIT  = 5'd17;

  typedef struct packed {
    logic [2:0]           op;
    logic [2:0]           sel;
    logic [FCRM_PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [FCRM_PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_JMP, sel: SP_MID, target: L_START};
    case (pc)
      5'd0:  w = '{op: OP_RD,   sel: SP_MID, target: L_START};
      5'd1:  w = '{op: OP_WR,   sel: SP_MID, target: L_START};
      5'd2:  w = '{op: OP_RD,   sel: SP_TOP, target: L_START};
      5'd3:  w = '{op: OP_WR,   sel: SP_TOP, target: L_START};
      5'd4:  w = '{op: OP_RD,   sel: SP_BOT, target: L_START};
      5'd5:  w = '{op: OP_WR,   sel: SP_BOT, target: L_START};
      5'd6:  w = '{op: OP_TEST, sel: SP_MID, target: L_EMIT};
      5'd7:  w = '{op: OP_STEP, sel: SP_MID, target: L_START};
      5'd8:  w = '{op: OP_RD,   sel: SP_PY,  target: L_START};
      5'd9:  w = '{op: OP_WR,   sel: SP_PY,  target: L_START};
      5'd10: w = '{op: OP_RD,   sel: SP_NY,  target: L_START};
      5'd11: w = '{op: OP_WR,   sel: SP_NY,  target: L_START};
      5'd12: w = '{op: OP_RD,   sel: SP_PX,  target: L_START};
      5'd13: w = '{op: OP_WR,   sel: SP_PX,  target: L_START};
      5'd14: w = '{op: OP_RD,   sel: SP_NX,  target: L_START};
      5'd15: w = '{op: OP_WR,   sel: SP_NX,  target: L_START};
      5'd16: w = '{op: OP_JMP,  sel: SP_MID, target: L_LOOP};
      5'd17: w = '{op: OP_ERD,  sel: SP_MID, target: L_START};
      5'd18: w = '{op: OP_EOUT, sel: SP_MID, target: L_EMIT};
      default: w = '{op: OP_JMP, sel: SP_MID, target: L_START};
    endcase
    return w;
  endfunction

  // columns lo..hi-1 set
  function automatic logic [FCRM_ROWS-1:0] span_mask(input logic [6:0] lo,
                                                     input logic [6:0] hi);
    logic [FCRM_ROWS-1:0] m;
    m = '0;
    for (int i = 0; i < FCRM_ROWS; i++) begin
      m[i] = (7'(i) >= lo) && (7'(i) < hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/filled_circle_row_masks.sv]
// Throughput: one request at a time; the midpoint step count is roughly
//   r/sqrt(2), and each row is then read from the 64-row mask memory and
//   emitted, held while out_stall is high.
// Reset: rst clears the sequencer, the output beat and the row valid bits.
// ----------------------------------------------------------------------------
// filled_circle_row_masks
// Rasterizes a filled disc of radius r into 2r row masks with a microcoded
// midpoint circle sequencer driving a row memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "filled_circle_row_masks_macros.svh"

module filled_circle_row_masks #(
  parameter int MAX_RADIUS = fcrm_pkg::FCRM_MAX_RADIUS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  disc_radius,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       row_index,
  output logic [63:0]      row_bits,
  output logic             last_row
);

  import fcrm_pkg::*;

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic                 busy;
  logic [FCRM_PC_W-1:0] pc;
  logic [6:0]           r;
  logic [6:0]           side;
  logic signed [9:0]    f;
  logic signed [8:0]    ddx;
  logic signed [8:0]    ddy;
  logic [6:0]           x;
  logic [6:0]           y;
  logic [6:0]           k;

  uword_t uw;
  assign uw = ucode(pc);

  // A request is taken only while the sequencer is idle.
  assign in_stall = busy;

  logic in_take;
  assign in_take = in_valid && !busy;

  // Clamp the radius to 1..MAX_RADIUS.
  logic [6:0] r_in;
  always_comb begin
    r_in = {1'b0, disc_radius};
    if (disc_radius == 6'd0) begin
      r_in = 7'd1;
    end else if (r_in > 7'(MAX_RADIUS)) begin
      r_in = 7'(MAX_RADIUS);
    end
  end

  // --------------------------------------------------------------------------
  // Span decode: row, first column and end column of the selected span.
  // All values stay within 0..64, so no underflow handling is needed.
  // --------------------------------------------------------------------------
  logic [6:0] sp_row;
  logic [6:0] sp_lo;
  logic [6:0] sp_hi;

  always_comb begin
    case (uw.sel)
      SP_TOP: begin
        sp_row = 7'd0;
        sp_lo  = r;
        sp_hi  = r + 7'd1;
      end
      SP_BOT: begin
        sp_row = side - 7'd1;
        sp_lo  = r;
        sp_hi  = r + 7'd1;
      end
      SP_PY: begin
        sp_row = r + y;
        sp_lo  = r - x;
        sp_hi  = r + x;
      end
      SP_NY: begin
        sp_row = r - y;
        sp_lo  = r - x;
        sp_hi  = r + x;
      end
      SP_PX: begin
        sp_row = r + x;
        sp_lo  = r - y;
        sp_hi  = r + y;
      end
      SP_NX: begin
        sp_row = r - x;
        sp_lo  = r - y;
        sp_hi  = r + y;
      end
      default: begin
        sp_row = r;
        sp_lo  = 7'd0;
        sp_hi  = side;
      end
    endcase
  end

  // Rows past the box (row 2r when x or y equals r) are dropped.
  logic sp_row_ok;
  assign sp_row_ok = sp_row < side;

  // --------------------------------------------------------------------------
  // Row memory with per-row valid bits; an unwritten row reads as zero.
  // --------------------------------------------------------------------------
  logic [FCRM_ROWS-1:0] mem [FCRM_ROWS];
  logic [FCRM_ROWS-1:0] row_valid;
  logic [FCRM_ROWS-1:0] rd_data;
  logic                 rd_valid;
  logic [FCRM_ROWS-1:0] rd_bits;

  logic       mem_re;
  logic [5:0] mem_raddr;
  logic       mem_we;
  logic [5:0] mem_waddr;
  logic [FCRM_ROWS-1:0] mem_wdata;

  assign rd_bits = rd_valid ? rd_data : '0;

  assign mem_re    = busy && (uw.op == OP_RD || uw.op == OP_ERD);
  assign mem_raddr = (uw.op == OP_ERD) ? k[5:0] : sp_row[5:0];
  assign mem_we    = busy && (uw.op == OP_WR) && sp_row_ok;
  assign mem_waddr = sp_row[5:0];
  assign mem_wdata = rd_bits | span_mask(sp_lo, sp_hi);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data  <= mem[mem_raddr];
      rd_valid <= row_valid[mem_raddr];
    end
  end

  // Clear every row at the start of a request; mark rows as they are written.
  always_ff @(posedge clk) begin
    if (rst || in_take) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[mem_waddr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Midpoint step: if f >= 0 drop y and add the grown ddy, then advance x
  // and add the grown ddx.
  // --------------------------------------------------------------------------
  logic signed [8:0] ddx_next;
  logic signed [8:0] ddy_next;
  logic signed [9:0] f_mid;
  logic signed [9:0] f_next;
  logic              f_pos;

  assign f_pos    = !f[9];
  assign ddx_next = ddx + 9'sd2;
  assign ddy_next = f_pos ? ddy + 9'sd2 : ddy;
  assign f_mid    = f_pos ? f + {ddy_next[8], ddy_next} : f;
  assign f_next   = f_mid + {ddx_next[8], ddx_next};

  // --------------------------------------------------------------------------
  // Output beat: load when the register is free or its beat leaves now.
  // --------------------------------------------------------------------------
  logic out_free;
  logic load_out;
  logic k_last;

  assign out_free = !out_valid || !out_stall;
  assign load_out = busy && (uw.op == OP_EOUT) && out_free;
  assign k_last   = (k == side - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      row_index <= k[5:0];
      row_bits  <= rd_bits;
      last_row  <= k_last;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: the step counter walks the microcode ROM.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= L_START;
    end else if (in_take) begin
      busy <= 1'b1;
      pc   <= L_START;
    end else if (busy) begin
      case (uw.op)
        OP_TEST: begin
          // continue while x < y, else go emit
          pc <= (x < y) ? pc + 5'd1 : uw.target;
        end
        OP_JMP: begin
          pc <= uw.target;
        end
        OP_EOUT: begin
          // hold until the output register frees up
          if (out_free) begin
            if (k_last) begin
              busy <= 1'b0;
            end else begin
              pc <= uw.target;
            end
          end
        end
        default: begin
          pc <= pc + 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r    <= r_in;
      side <= {r_in[5:0], 1'b0};
      f    <= 10'sd1 - $signed({3'b000, r_in});
      ddx  <= 9'sd1;
      ddy  <= 9'sd0 - $signed({1'b0, r_in, 1'b0});
      x    <= 7'd0;
      y    <= r_in;
      k    <= 7'd0;
    end else if (busy && uw.op == OP_STEP) begin
      f   <= f_next;
      ddx <= ddx_next;
      ddy <= ddy_next;
      x   <= x + 7'd1;
      if (f_pos) begin
        y <= y - 7'd1;
      end
    end else if (load_out) begin
      k <= k + 7'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FCRM_ASSERT_NXT(a_take_starts, in_take, busy && pc == L_START, "request did not start program")
  `FCRM_ASSERT_NXT(a_more_rows, out_valid && !out_stall && !last_row, busy || last_row, "early stop")
  `FCRM_ASSERT_IMP(a_row_in_box, load_out, k < side, "emitted row outside the box")

endmodule

`default_nettype wire
